// ----- src/deq_pkg.sv -----
// Shared types and constants for the double-ended queue unit.
package deq_pkg;

    // Fixed field widths of the transaction ports
    localparam int OPCODE_BITS = 3;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 7;

    // Value returned by a pop or peek on an empty queue (-1)
    localparam logic [VALUE_BITS-1:0] EMPTY_READ = '1;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } t_opcode;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the incoming transaction
        logic exec;      // update pointers, write or launch a read
        logic load_rd;   // take the word read from the store
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic needs_read; // current operation reads the store
    } t_dp_stat;

endpackage

// ----- src/deq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/deq_ctrl.sv -----
// Controller state machine: sequences accept, execute, store read and result.
module deq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  deq_pkg::t_dp_stat  i_stat,
    output deq_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.needs_read ? S_READ : S_DONE;
            end
            S_READ: begin
                o_cmd.load_rd = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/deq_dp.sv -----
// Datapath: ring pointers, entry count, word store and result registers.
module deq_dp #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  deq_pkg::t_dp_cmd                    i_cmd,
    output deq_pkg::t_dp_stat                   o_stat,
    input  logic [deq_pkg::OPCODE_BITS-1:0]     i_opcode,
    input  logic signed [deq_pkg::VALUE_BITS-1:0] i_push_value,
    output logic signed [deq_pkg::VALUE_BITS-1:0] o_read_value,
    output logic [deq_pkg::STATUS_BITS-1:0]     o_status,
    output logic [deq_pkg::COUNT_BITS-1:0]      o_entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VB = deq_pkg::VALUE_BITS;

    logic [deq_pkg::OPCODE_BITS-1:0] r_op;
    logic [WORD_BITS-1:0]            r_val;
    logic [AW-1:0]                   r_front;
    logic [AW-1:0]                   r_back;
    logic [CW-1:0]                   r_count;
    logic [VB-1:0]                   r_read_value;
    deq_pkg::t_status                r_status;

    logic [AW-1:0]                   n_front;
    logic [AW-1:0]                   n_back;
    logic [CW-1:0]                   n_count;
    logic [VB-1:0]                   n_read_value;
    deq_pkg::t_status                n_status;

    logic                            needs_read;
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic [AW-1:0]                   rd_addr;
    logic [WORD_BITS-1:0]            rd_data;
    logic                            is_full;
    logic                            is_empty;
    logic [WORD_BITS+VB-1:0]         val_ext;
    logic [VB+WORD_BITS-1:0]         rd_ext;
    logic [CW+deq_pkg::COUNT_BITS-1:0] cnt_ext;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] idx);
        return (idx == '0) ? AW'(DEPTH - 1) : idx - AW'(1);
    endfunction

    // Keep the low WORD_BITS of the pushed value
    assign val_ext = {{WORD_BITS{1'b0}}, i_push_value};

    // Latch the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_val <= val_ext[WORD_BITS-1:0];
        end
    end

    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // Operation decode: pointer and count updates, store access, early result
    always_comb begin
        n_front      = r_front;
        n_back       = r_back;
        n_count      = r_count;
        n_read_value = '0;
        n_status     = deq_pkg::ST_OK;
        needs_read   = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_back;
        rd_addr      = r_front;
        unique case (r_op) inside
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                if (is_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                    if (r_op == deq_pkg::OP_PUSH_FRONT) begin
                        n_front = prev_slot(r_front);
                        wr_addr = prev_slot(r_front);
                    end else begin
                        wr_addr = r_back;
                        n_back  = next_slot(r_back);
                    end
                end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK,
            deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_BACK: begin
                if (is_empty) begin
                    n_status     = deq_pkg::ST_EMPTY;
                    n_read_value = deq_pkg::EMPTY_READ;
                end else begin
                    needs_read = 1'b1;
                    case (r_op)
                        deq_pkg::OP_POP_FRONT: begin
                            rd_addr = r_front;
                            n_front = next_slot(r_front);
                            n_count = r_count - CW'(1);
                        end
                        deq_pkg::OP_POP_BACK: begin
                            rd_addr = prev_slot(r_back);
                            n_back  = prev_slot(r_back);
                            n_count = r_count - CW'(1);
                        end
                        deq_pkg::OP_PEEK_FRONT: begin
                            rd_addr = r_front;
                        end
                        default: begin
                            rd_addr = prev_slot(r_back);
                        end
                    endcase
                end
            end
            default: begin
                // unused opcodes leave the queue alone
                n_status = deq_pkg::ST_OK;
            end
        endcase
    end

    assign o_stat.needs_read = needs_read;

    // Word store
    deq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && wr_en),
        .i_waddr (wr_addr),
        .i_wdata (r_val),
        .i_re    (i_cmd.exec && needs_read),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Pointer and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    // Sign-extend the stored word to the result width
    assign rd_ext = {{VB{rd_data[WORD_BITS-1]}}, rd_data};

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end else if (i_cmd.load_rd) begin
            r_read_value <= rd_ext[VB-1:0];
        end
    end

    assign cnt_ext       = {{deq_pkg::COUNT_BITS{1'b0}}, r_count};
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_entry_count = cnt_ext[deq_pkg::COUNT_BITS-1:0];

endmodule

// ----- src/double_ended_queue_unit.sv -----
// Top level of the double-ended queue unit: controller, datapath and checks.
//
// Bounded double-ended queue of up to DEPTH words of WORD_BITS bits in a ring
// buffer. Each input transaction carries an opcode (push front/back, pop
// front/back, peek front/back) and a push value; each produces exactly one
// result transaction with the word read (sign-extended, -1 when empty, 0 for
// pushes and unused opcodes), a status (ok, empty, full) and the entry count
// after the operation (modulo 128). A push on a full queue is dropped. One
// transaction is handled at a time. A push, a pop or peek on an empty queue,
// or an unused opcode goes from the execute state straight to the result
// state; a successful pop or peek passes through a read state between them,
// because the word store has a single registered read port. The next
// transaction is accepted in the cycle after the result is taken. No clearing
// pass is needed after reset.
module double_ended_queue_unit #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [deq_pkg::OPCODE_BITS-1:0]       i_opcode,
    input  logic signed [deq_pkg::VALUE_BITS-1:0] i_push_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [deq_pkg::VALUE_BITS-1:0] o_read_value,
    output logic [deq_pkg::STATUS_BITS-1:0]       o_status,
    output logic [deq_pkg::COUNT_BITS-1:0]        o_entry_count
);

    deq_pkg::t_dp_cmd  cmd;
    deq_pkg::t_dp_stat stat;

    // Sequencer
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Pointers, count and word store
    deq_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_opcode      (i_opcode),
        .i_push_value  (i_push_value),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

`ifndef NO_ASSERTIONS
    // No new transaction is taken while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input accepted while result pending");

    // A full status reports a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == deq_pkg::ST_FULL)
            |-> o_entry_count == deq_pkg::COUNT_BITS'(DEPTH))
        else $error("full status with wrong entry count");

    // An empty status reports zero entries and reads -1
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == deq_pkg::ST_EMPTY)
            |-> (o_entry_count == '0 && o_read_value == deq_pkg::EMPTY_READ))
        else $error("empty status with wrong result");

    // A result is offered after every accepted transaction
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##[2:3] o_out_valid)
        else $error("no result after accept");
`endif

endmodule

// ----- bench/tb_double_ended_queue_unit.sv -----
// Self-checking testbench for the double-ended queue unit: directed table, then random traffic.
module tb_double_ended_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int WORD_BITS    = 32;
    localparam int IDX_BITS     = $clog2(DEPTH);
    localparam int STALL_LIMIT  = 4000;
    localparam int SEGMENTS     = 16;
    localparam int SEG_ITEMS    = 100;
    localparam int DRAIN_CYCLES = 10;

    // Opcodes the block ignores
    localparam logic [deq_pkg::OPCODE_BITS-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [deq_pkg::OPCODE_BITS-1:0] OP_UNUSED_B = 3'd7;

    // Traffic mix of a random segment
    localparam int MIX_FILL    = 0;
    localparam int MIX_DRAIN   = 1;
    localparam int MIX_BALANCE = 2;

    typedef struct packed {
        logic signed [deq_pkg::VALUE_BITS-1:0] rd;
        logic [deq_pkg::STATUS_BITS-1:0]       st;
        logic [deq_pkg::COUNT_BITS-1:0]        cnt;
    } t_deq_result;

    // One row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        logic [deq_pkg::OPCODE_BITS-1:0] op;
        logic [deq_pkg::VALUE_BITS-1:0]  val;
        logic                            typed;
        t_deq_result                     res;
    } t_dir_row;

    // Expected result of a pop or peek on an empty queue
    localparam t_deq_result RES_EMPTY = '{deq_pkg::EMPTY_READ, deq_pkg::ST_EMPTY, 7'd0};
    localparam t_deq_result NO_RES    = '0;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    // Block inputs, known from time zero
    logic                                  in_valid  = 1'b0;
    logic [deq_pkg::OPCODE_BITS-1:0]       in_opcode = '0;
    logic signed [deq_pkg::VALUE_BITS-1:0] in_value  = '0;
    logic                                  out_ready = 1'b0;

    logic                                  o_in_ready;
    logic                                  o_out_valid;
    logic signed [deq_pkg::VALUE_BITS-1:0] o_read_value;
    logic [deq_pkg::STATUS_BITS-1:0]       o_status;
    logic [deq_pkg::COUNT_BITS-1:0]        o_entry_count;

    double_ended_queue_unit #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (in_opcode),
        .i_push_value  (in_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    // Shadow deque: ring of words, front index, one-past-back index, fill count
    logic [WORD_BITS-1:0]           ring_words [DEPTH];
    logic [IDX_BITS-1:0]            head_idx = '0;
    logic [IDX_BITS-1:0]            tail_idx = '0;
    logic [deq_pkg::COUNT_BITS-1:0] fill_cnt = '0;

    t_deq_result pending_q [$];
    t_dir_row    dir_rows [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent_cnt       = 0;
    int checked_cnt    = 0;
    int mismatch_cnt   = 0;
    int fail_cnt       = 0;
    int full_hits      = 0;
    int empty_hits     = 0;
    int idle_cycles    = 0;

    // Successful push or unused opcode: reads 0, status ok, given count
    function automatic t_deq_result ok_res(input logic [deq_pkg::COUNT_BITS-1:0] cnt);
        t_deq_result r;
        r.rd  = '0;
        r.st  = deq_pkg::ST_OK;
        r.cnt = cnt;
        return r;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(input logic [deq_pkg::OPCODE_BITS-1:0] op,
                                    input logic [deq_pkg::VALUE_BITS-1:0] val,
                                    input logic typed, input t_deq_result res);
        t_dir_row row;
        row.op    = op;
        row.val   = val;
        row.typed = typed;
        row.res   = res;
        dir_rows.push_back(row);
    endfunction

    // Apply one operation to the shadow deque and return the result it yields.
    // DEPTH is a power of two, so index arithmetic wraps at IDX_BITS.
    function automatic t_deq_result apply_deq_op(
            input logic [deq_pkg::OPCODE_BITS-1:0] op,
            input logic [deq_pkg::VALUE_BITS-1:0] val);
        t_deq_result r;
        r.rd = '0;
        r.st = deq_pkg::ST_OK;
        case (op)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                if (fill_cnt >= DEPTH) begin
                    r.st = deq_pkg::ST_FULL;
                end else if (op == deq_pkg::OP_PUSH_FRONT) begin
                    head_idx = head_idx - 1'b1;
                    ring_words[head_idx] = val[WORD_BITS-1:0];
                    fill_cnt = fill_cnt + 1'b1;
                end else begin
                    ring_words[tail_idx] = val[WORD_BITS-1:0];
                    tail_idx = tail_idx + 1'b1;
                    fill_cnt = fill_cnt + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK,
            deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_BACK: begin
                if (fill_cnt == 0) begin
                    r.st = deq_pkg::ST_EMPTY;
                    r.rd = deq_pkg::EMPTY_READ;
                end else if (op == deq_pkg::OP_POP_FRONT) begin
                    r.rd = ring_words[head_idx];
                    head_idx = head_idx + 1'b1;
                    fill_cnt = fill_cnt - 1'b1;
                end else if (op == deq_pkg::OP_POP_BACK) begin
                    tail_idx = tail_idx - 1'b1;
                    r.rd = ring_words[tail_idx];
                    fill_cnt = fill_cnt - 1'b1;
                end else if (op == deq_pkg::OP_PEEK_FRONT) begin
                    r.rd = ring_words[head_idx];
                end else begin
                    r.rd = ring_words[tail_idx - 1'b1];
                end
            end
            default: ;  // unused opcode: no effect
        endcase
        r.cnt = fill_cnt;
        return r;
    endfunction

    // Present one transaction, wait for acceptance, record its expected result
    task automatic send_deq_op(input logic [deq_pkg::OPCODE_BITS-1:0] op,
                               input logic [deq_pkg::VALUE_BITS-1:0] val,
                               input logic typed, input t_deq_result typed_res);
        t_deq_result pred;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_value  <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = apply_deq_op(op, val);
        pending_q.push_back(typed ? typed_res : pred);
        sent_cnt++;
    endtask

    // Random opcode weighted by segment mix; a few unused opcodes mixed in
    function automatic logic [deq_pkg::OPCODE_BITS-1:0] pick_opcode(input int mix);
        int r;
        int push_pct;
        r = $urandom_range(99);
        push_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 25 : 45;
        if (r < 3)
            return ($urandom_range(1) != 0) ? OP_UNUSED_A : OP_UNUSED_B;
        if (r < 3 + push_pct)
            return ($urandom_range(1) != 0) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
        case ($urandom_range(3))
            0:       return deq_pkg::OP_POP_FRONT;
            1:       return deq_pkg::OP_POP_BACK;
            2:       return deq_pkg::OP_PEEK_FRONT;
            default: return deq_pkg::OP_PEEK_BACK;
        endcase
    endfunction

    // Mostly random words, sometimes the signed extremes, zero and all ones
    function automatic logic [deq_pkg::VALUE_BITS-1:0] pick_value();
        case ($urandom_range(11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Receiver back-pressure
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_deq_result exp_res;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_q.size() == 0) begin
                fail_cnt++;
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("[%0t] unexpected result: rd=%0d st=%0d cnt=%0d",
                             $realtime, o_read_value, o_status, o_entry_count);
            end else begin
                exp_res = pending_q.pop_front();
                checked_cnt++;
                if (exp_res.st == deq_pkg::ST_FULL)  full_hits++;
                if (exp_res.st == deq_pkg::ST_EMPTY) empty_hits++;
                if (o_read_value !== exp_res.rd || o_status !== exp_res.st ||
                    o_entry_count !== exp_res.cnt) begin
                    fail_cnt++;
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("[%0t] result %0d mismatch: rd exp %0d got %0d,",
                                 $realtime, checked_cnt, exp_res.rd, o_read_value);
                        $display("    st exp %0d got %0d, cnt exp %0d got %0d",
                                 exp_res.st, o_status, exp_res.cnt, o_entry_count);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results pending",
                         STALL_LIMIT, pending_q.size());
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus
    initial begin
        int seg;
        int n;
        logic [deq_pkg::OPCODE_BITS-1:0] op;

        // Empty-queue reads, unused opcodes, then extremes and both wrap directions
        add_row(deq_pkg::OP_POP_FRONT,  32'h1234_5678, 1'b1, RES_EMPTY);
        add_row(deq_pkg::OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, RES_EMPTY);
        add_row(deq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 1'b1, RES_EMPTY);
        add_row(deq_pkg::OP_PEEK_BACK,  32'h8000_0000, 1'b1, RES_EMPTY);
        add_row(OP_UNUSED_A,            32'hDEAD_BEEF, 1'b1, ok_res(7'd0));
        add_row(OP_UNUSED_B,            32'hFFFF_FFFF, 1'b1, ok_res(7'd0));
        add_row(deq_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, ok_res(7'd1));
        add_row(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b1, ok_res(7'd2));
        add_row(deq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 1'b0, NO_RES);
        add_row(deq_pkg::OP_PEEK_BACK,  32'hFFFF_FFFF, 1'b0, NO_RES);
        add_row(deq_pkg::OP_PUSH_BACK,  32'h0000_0000, 1'b0, NO_RES);
        add_row(deq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, NO_RES);
        add_row(deq_pkg::OP_PUSH_BACK,  32'h0000_0001, 1'b0, NO_RES);
        add_row(OP_UNUSED_B,            32'h5A5A_5A5A, 1'b0, NO_RES);
        add_row(deq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, NO_RES);
        add_row(deq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b0, NO_RES);
        add_row(deq_pkg::OP_POP_FRONT,  32'hFFFF_FFFF, 1'b0, NO_RES);
        add_row(deq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b0, NO_RES);
        add_row(deq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, NO_RES);
        add_row(deq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b1, RES_EMPTY);
        add_row(deq_pkg::OP_PUSH_FRONT, 32'h5555_5555, 1'b0, NO_RES);
        add_row(deq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b0, NO_RES);
        add_row(deq_pkg::OP_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, NO_RES);
        add_row(deq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, NO_RES);

        // Hold reset, then release it
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, no idling
        foreach (dir_rows[i])
            send_deq_op(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);

        // Random segments: idle mode and traffic mix rotate independently
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            n = 0;
            while (n < SEG_ITEMS) begin
                op = pick_opcode(seg % 3);
                send_deq_op(op, pick_value(), 1'b0, NO_RES);
                if (op != OP_UNUSED_A && op != OP_UNUSED_B)
                    n++;
            end
            // Sender holds off mid-run until every pending result has come back
            if (seg == SEGMENTS / 2) begin
                in_valid <= 1'b0;
                while (pending_q.size() != 0) @(posedge i_clk);
            end
        end

        // Drain outstanding results, then watch for stray outputs
        in_valid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d transactions sent, %0d results checked, %0d mismatches.",
                 sent_cnt, checked_cnt, mismatch_cnt);
        $display("Full-queue push rejections: %0d, empty-queue reads: %0d.",
                 full_hits, empty_hits);
        if (fail_cnt == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
